[sv/dns_wire_name_to_dotted_macros.svh]
// Assertion macros shared by the checker of the DNS name converter.
// No dependencies; included by files that hold concurrent assertions.
`ifndef DNS_WIRE_NAME_TO_DOTTED_MACROS_SVH
`define DNS_WIRE_NAME_TO_DOTTED_MACROS_SVH

// Property sampled on the rising clock, off while reset is low
`define DWND_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Same-cycle implication
`define DWND_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DWND_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/dwnd_pkg.sv]
// Shared types, constants and character helpers for the DNS name converter.
// No dependencies; imported by dwnd_core, dwnd_skid and the top level.
package dwnd_pkg;

    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] MAX_LEN_RESET   = 8'd253;
    localparam logic [BYTE_W-1:0] CASE_OFFSET     = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_DOT        = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_HYPHEN     = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_Z    = 8'h7A;
    localparam logic [BYTE_W-1:0] CHAR_DIGIT_0    = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_DIGIT_9    = 8'h39;

    // One result item
    typedef struct packed {
        logic [BYTE_W-1:0] text_char;
        logic              char_valid;
        logic              last;
        logic [BYTE_W-1:0] text_length;
    } t_result;

    // Fold upper-case letters to lower case
    function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            r = b + CASE_OFFSET;
        end
        return r;
    endfunction

    // Letter, digit, hyphen or underscore (after folding)
    function automatic logic is_name_char(input logic [BYTE_W-1:0] b);
        return (b inside {[CHAR_LOWER_A:CHAR_LOWER_Z], [CHAR_DIGIT_0:CHAR_DIGIT_9],
                          CHAR_HYPHEN, CHAR_UNDERSCORE});
    endfunction

endpackage

[sv/dwnd_core.sv]
// Per-byte parser: holds the name state and the length limit, turns one
// registered wire byte into zero or one result item. Depends on dwnd_pkg.
module dwnd_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [7:0]            i_cfg_wr_data,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    input  logic                  i_start,
    output logic                  o_res_valid,
    output dwnd_pkg::t_result     o_res
);
    import dwnd_pkg::*;

    logic [BYTE_W-1:0] r_max_len;
    logic [BYTE_W-1:0] r_label_left, n_label_left;
    logic [BYTE_W-1:0] r_out_count,  n_out_count;
    logic              r_seen_label, n_seen_label;
    logic              r_finished,   n_finished;

    logic [BYTE_W-1:0] cur_left;
    logic [BYTE_W-1:0] cur_count;
    logic [BYTE_W-1:0] inc_count;
    logic [BYTE_W-1:0] low_byte;
    logic              cur_seen;
    logic              cur_fin;

    // Start clears the parse state before the byte is handled
    always_comb begin
        cur_left  = i_start ? '0 : r_label_left;
        cur_count = i_start ? '0 : r_out_count;
        cur_seen  = i_start ? 1'b0 : r_seen_label;
        cur_fin   = i_start ? 1'b0 : r_finished;
        inc_count = cur_count + 8'd1;
        low_byte  = to_lower(i_byte);
    end

    // Decide the result and the next state for this byte
    always_comb begin
        n_label_left      = cur_left;
        n_out_count       = cur_count;
        n_seen_label      = cur_seen;
        n_finished        = cur_fin;
        o_res_valid       = 1'b0;
        o_res.text_char   = '0;
        o_res.char_valid  = 1'b0;
        o_res.last        = 1'b1;
        o_res.text_length = cur_count;
        if (i_start && (r_max_len == '0)) begin
            // zero limit: end marker right away
            o_res_valid = 1'b1;
            n_finished  = 1'b1;
        end else if (cur_fin) begin
            // ended or idle: drop the byte
        end else if (cur_left != '0) begin
            n_label_left = cur_left - 8'd1;
            if (is_name_char(low_byte)) begin
                o_res_valid       = 1'b1;
                o_res.text_char   = low_byte;
                o_res.char_valid  = 1'b1;
                o_res.last        = (inc_count >= r_max_len);
                o_res.text_length = inc_count;
                n_out_count       = inc_count;
                n_finished        = (inc_count >= r_max_len);
            end
        end else if (i_byte == '0) begin
            // root label ends the name
            o_res_valid = 1'b1;
            n_finished  = 1'b1;
        end else begin
            n_label_left = i_byte;
            n_seen_label = 1'b1;
            if (cur_seen) begin
                o_res_valid       = 1'b1;
                o_res.text_char   = CHAR_DOT;
                o_res.char_valid  = 1'b1;
                o_res.last        = (inc_count >= r_max_len);
                o_res.text_length = inc_count;
                n_out_count       = inc_count;
                n_finished        = (inc_count >= r_max_len);
            end
        end
    end

    // Hold parse state; advance it only on a processed byte; the limit loads on a cfg write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len    <= MAX_LEN_RESET;
            r_label_left <= '0;
            r_out_count  <= '0;
            r_seen_label <= 1'b0;
            r_finished   <= 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            if (i_step) begin
                r_label_left <= n_label_left;
                r_out_count  <= n_out_count;
                r_seen_label <= n_seen_label;
                r_finished   <= n_finished;
            end
        end
    end

endmodule

[sv/dwnd_skid.sv]
// Two-entry result buffer: registered output plus one skid entry, so the
// push side sees a registered ready. Depends on dwnd_pkg.
module dwnd_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    input  dwnd_pkg::t_result i_push_res,
    output logic              o_push_ready,
    output logic              o_valid,
    output dwnd_pkg::t_result o_res,
    input  logic              i_pop_ready
);
    import dwnd_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop          = r_main_valid && i_pop_ready;
    assign o_push_ready = !r_skid_valid;
    assign o_valid      = r_main_valid;
    assign o_res        = r_main;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push_valid;
            end
        end else if (i_push_valid && !r_skid_valid) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    // Move payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else begin
                r_main <= i_push_res;
            end
        end else if (i_push_valid && !r_skid_valid) begin
            if (r_main_valid) begin
                r_skid <= i_push_res;
            end else begin
                r_main <= i_push_res;
            end
        end
    end

endmodule

[sv/dns_wire_name_to_dotted.sv]
// Top level of the DNS wire-name to dotted-text converter.
// Depends on dwnd_pkg, dwnd_core and dwnd_skid.
//
//  Channel  | Direction | Payload
//  ---------+-----------+---------------------------------------------------
//  s stream | in        | tdata = wire_byte, tuser = name_start
//  m stream | out       | tdata = text_char, text_length; tuser = char_valid;
//           |           | tlast = last
//  cfg      | in        | wr_data = max_len, taken when wr_en is high
//
// One byte per cycle sustained while the m side does not stall. An accepted byte
// is registered in the input register, parsed there in one pass, and its result
// is registered in the output register, or in the skid entry if the output is
// still held. A stall on the m side fills the skid entry with the result in
// flight; the registered ready then holds the s side until the stall clears. Reset is
// synchronous, active low, and leaves the block idle until a byte with name_start.
module dns_wire_name_to_dotted (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,   // max_len
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,       // [7:0] wire_byte
    input  logic        i_s_tuser,       // [0] name_start
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,       // [7:0] text_char, [15:8] text_length
    output logic        o_m_tuser,       // [0] char_valid
    output logic        o_m_tlast        // last
);
    import dwnd_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_start;
    logic              out_ready;
    logic              step;
    logic              res_valid;
    t_result           res;
    t_result           m_res;

    assign step       = r_in_valid && out_ready;
    assign o_s_tready = !r_in_valid || out_ready;

    // Input register: load on accept, drop when parsed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte  <= i_s_tdata;
            r_in_start <= i_s_tuser;
        end
    end

    dwnd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (step),
        .i_byte        (r_in_byte),
        .i_start       (r_in_start),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    dwnd_skid u_skid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (step && res_valid),
        .i_push_res   (res),
        .o_push_ready (out_ready),
        .o_valid      (o_m_tvalid),
        .o_res        (m_res),
        .i_pop_ready  (i_m_tready)
    );

    assign o_m_tdata = {m_res.text_length, m_res.text_char};
    assign o_m_tuser = m_res.char_valid;
    assign o_m_tlast = m_res.last;

endmodule

[sv/dwnd_checker.sv]
// Port-level checks for the DNS name converter, bound to the top level.
// Depends on dns_wire_name_to_dotted_macros.svh.
`include "dns_wire_name_to_dotted_macros.svh"

module dwnd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        o_m_tlast
);

    // Hold a stalled result
    `DWND_ASSERT_NXT(a_valid_held, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid, "result dropped while stalled")
    `DWND_ASSERT_NXT(a_data_held, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast), "stalled result changed")

    // End markers close the name and carry no character
    `DWND_ASSERT_IMP(a_end_is_last, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tlast, "end marker without last")
    `DWND_ASSERT_IMP(a_end_no_char, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tdata[7:0] == 8'd0, "end marker with a character")

    // A character always counts itself
    `DWND_ASSERT(a_char_len, i_clk, i_rst_n, (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[15:8] != 8'd0), "character with zero length")

endmodule

bind dns_wire_name_to_dotted dwnd_checker u_dwnd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
